### src/mf2d_pkg.sv
// ----------------------------------------------------------------------------
// mf2d_pkg
// Shared constants for the 2-D median filter: pixel width, register indexes
// and request kinds.
// ----------------------------------------------------------------------------
package mf2d_pkg;

  localparam int PIX_W = 8;

  // configuration register indexes
  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // request kind carried in tuser
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

endpackage

### src/median_filter_2d.sv
// ----------------------------------------------------------------------------
// median_filter_2d
// Streaming 2-D median filter for 8-bit grayscale pixels in raster order.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one beat per pixel; tuser = 0 carries a pixel in
//   tdata, tuser = 1 is a drain beat that pushes out pending results.
//   Output stream (m_axis_*): filtered pixel in tdata, tlast on the last pixel
//   of the frame. Output begins once 2*r*w+2*r+1 pixels have arrived; after
//   that each beat yields at most one result. Pixels beyond the frame act as
//   drain beats and are dropped.
//   Config port: cfg_we_i writes register cfg_idx_i (0 radius, 1 width,
//   2 height) and restarts the frame. Write only while idle.
// Timing:
//   A beat that makes no result leaves the input ready for the next beat. A
//   beat with a result goes through accept, setup, eight passes of n reads,
//   n being the window size (up to 49 at radius 3), each pass followed by a
//   read latency wait and a decision, then output. The median is found bit
//   by bit, MSB first, one line-store read per cycle through the single read
//   port. The result then sits in the output register until taken; tready
//   stays low while the receiver stalls.
// Reset: frame counters clear, radius 1, width 1024, height 1024. The line
//   store is not cleared; only pixels of the current frame are ever read.
// ----------------------------------------------------------------------------
module median_filter_2d
  import mf2d_pkg::*;
#(
  parameter int MAX_RADIUS = 3,
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // config write port
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [12:0]      cfg_data_i,
  // input stream
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] pixel_in
  input  logic             s_axis_tuser,   // [0] req_type
  // output stream
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] filtered_pixel
  output logic             m_axis_tlast    // frame_last
);

  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int SW    = RW + 1;                       // span counters
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int TW    = WW + HW + 1;                  // linear pixel count
  localparam int DEPTH_MIN = (3 * MAX_RADIUS + 1) * MAX_WIDTH + 3 * MAX_RADIUS + 1;
  localparam int AW    = $clog2(DEPTH_MIN);
  localparam int WIN_MAX = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int CW    = $clog2(WIN_MAX + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_WAIT  = 3'd3;
  localparam logic [2:0] ST_RES   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  // ---------------- configuration ----------------
  logic [1:0]  radius_q;
  logic [10:0] width_q;
  logic [12:0] height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 2'd1;
      width_q  <= 11'd1024;
      height_q <= 13'd1024;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS: radius_q <= cfg_data_i[1:0];
        REG_WIDTH:  width_q  <= cfg_data_i[10:0];
        REG_HEIGHT: height_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // effective values: zero width or height means one, large values saturate
  logic [RW-1:0] r_eff;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [SW-1:0] span;
  logic [TW-1:0] total;
  logic [TW-1:0] lat;

  always_comb begin
    r_eff = (32'(radius_q) > MAX_RADIUS) ? RW'(MAX_RADIUS) : RW'(radius_q);
    if (width_q == '0)                     w_eff = WW'(1);
    else if (32'(width_q) > MAX_WIDTH)     w_eff = WW'(MAX_WIDTH);
    else                                   w_eff = WW'(width_q);
    if (height_q == '0)                    h_eff = HW'(1);
    else if (32'(height_q) > MAX_HEIGHT)   h_eff = HW'(MAX_HEIGHT);
    else                                   h_eff = HW'(height_q);
    span  = SW'({r_eff, 1'b1});
    total = TW'(w_eff) * TW'(h_eff);
    lat   = TW'({r_eff, 1'b0}) * TW'(w_eff) + TW'({r_eff, 1'b0});
  end

  // ---------------- control state ----------------
  logic [2:0]    state_q, state_d;
  logic [TW-1:0] in_cnt_q;
  logic [TW-1:0] out_cnt_q;
  logic [HW-1:0] out_row_q;
  logic [WW-1:0] out_col_q;

  // window scan
  logic [SW-1:0] rows_q, cols_q, y_q, x_q;
  logic [AW-1:0] addr_q, rowbase_q;
  logic [CW-1:0] k_q, cnt_q;
  logic [2:0]    bit_q;
  logic [7:0]    pref_q, mask_q;
  logic          rd_v_q;
  pix_t          rd_data_q;
  pix_t          out_pix_q;
  logic          out_last_q;

  // line store, ring addressed by the linear pixel index
  pix_t mem [2**AW];

  logic in_hs, out_hs, accepted, emit;
  logic [TW-1:0] in_next;
  logic [TW:0]   need;

  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_we_i;
  assign in_hs    = s_axis_tvalid && s_axis_tready;
  assign out_hs   = m_axis_tvalid && m_axis_tready;
  assign accepted = in_hs && (s_axis_tuser == REQ_PIXEL) && (in_cnt_q < total);
  assign in_next  = accepted ? in_cnt_q + TW'(1) : in_cnt_q;
  assign need     = {1'b0, out_cnt_q} + {1'b0, lat} + (TW+1)'(1);
  always_comb begin
    if (out_cnt_q >= total) emit = 1'b0;
    else if (accepted)      emit = {1'b0, in_next} >= need;
    else                    emit = (in_next == total);
  end

  always_ff @(posedge clk_i) begin
    if (accepted) mem[in_cnt_q[AW-1:0]] <= s_axis_tdata;
    rd_data_q <= mem[addr_q];
  end

  // window geometry for the current output position
  logic [RW-1:0] di, dj;
  logic [HW-1:0] i0;
  logic [WW-1:0] j0;
  logic [HW-1:0] rows_left;
  logic [WW-1:0] cols_left;
  logic [SW-1:0] rows_n, cols_n;
  logic [2*SW-1:0] n_win;
  logic [AW-1:0] start;

  always_comb begin
    di = (out_row_q > HW'(r_eff)) ? r_eff : RW'(out_row_q);
    dj = (out_col_q > WW'(r_eff)) ? r_eff : RW'(out_col_q);
    i0 = out_row_q - HW'(di);
    j0 = out_col_q - WW'(dj);
    rows_left = h_eff - i0;
    cols_left = w_eff - j0;
    rows_n = (rows_left < HW'(span)) ? SW'(rows_left) : span;
    cols_n = (cols_left < WW'(span)) ? SW'(cols_left) : span;
    n_win  = (2*SW)'(rows_n) * (2*SW)'(cols_n);
    start  = AW'(out_cnt_q) - AW'(TW'(di) * TW'(w_eff)) - AW'(dj);
  end

  // count of values matching the prefix with a zero at the current bit
  logic match;
  assign match = (((rd_data_q ^ pref_q) & mask_q) == 8'd0) && !rd_data_q[bit_q];

  logic last_issue;
  assign last_issue = (y_q == rows_q - SW'(1)) && (x_q == cols_q - SW'(1));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_hs && emit) state_d = ST_SETUP;
      ST_SETUP: state_d = ST_SCAN;
      ST_SCAN:  if (last_issue) state_d = ST_WAIT;
      ST_WAIT:  state_d = ST_RES;
      ST_RES:   state_d = (bit_q == 3'd0) ? ST_OUT : ST_SCAN;
      ST_OUT:   if (out_hs) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
    // a register write restarts the frame
    if (cfg_we_i) state_d = ST_IDLE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      out_row_q <= '0;
      out_col_q <= '0;
      rd_v_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= (state_q == ST_SCAN);
      if (cfg_we_i) begin
        in_cnt_q  <= '0;
        out_cnt_q <= '0;
        out_row_q <= '0;
        out_col_q <= '0;
      end else begin
        if (accepted) in_cnt_q <= in_next;
        if (state_q == ST_OUT && out_hs) begin
          if (out_last_q) begin
            in_cnt_q  <= '0;
            out_cnt_q <= '0;
            out_row_q <= '0;
            out_col_q <= '0;
          end else begin
            out_cnt_q <= out_cnt_q + TW'(1);
            if (out_col_q + WW'(1) >= w_eff) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + HW'(1);
            end else begin
              out_col_q <= out_col_q + WW'(1);
            end
          end
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (rd_v_q && match) cnt_q <= cnt_q + CW'(1);
    unique case (state_q)
      ST_SETUP: begin
        rows_q    <= rows_n;
        cols_q    <= cols_n;
        k_q       <= CW'(n_win >> 1);
        addr_q    <= start;
        rowbase_q <= start;
        y_q       <= '0;
        x_q       <= '0;
        bit_q     <= 3'd7;
        pref_q    <= 8'd0;
        mask_q    <= 8'd0;
        cnt_q     <= '0;
      end
      ST_SCAN: begin
        if (x_q == cols_q - SW'(1)) begin
          x_q       <= '0;
          y_q       <= y_q + SW'(1);
          addr_q    <= rowbase_q + AW'(w_eff);
          rowbase_q <= rowbase_q + AW'(w_eff);
        end else begin
          x_q    <= x_q + SW'(1);
          addr_q <= addr_q + AW'(1);
        end
      end
      ST_RES: begin
        if (k_q >= cnt_q) begin
          pref_q[bit_q] <= 1'b1;
          k_q           <= k_q - cnt_q;
        end
        mask_q[bit_q] <= 1'b1;
        bit_q         <= bit_q - 3'd1;
        cnt_q         <= '0;
        y_q           <= '0;
        x_q           <= '0;
        addr_q        <= start;
        rowbase_q     <= start;
        if (bit_q == 3'd0) begin
          out_pix_q  <= {pref_q[7:1], (k_q >= cnt_q)};
          out_last_q <= (out_cnt_q + TW'(1) == total);
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = (state_q == ST_OUT);
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;

endmodule
